/* sv/pls_pkg.sv */
// ----------------------------------------------------------------------------
// Positional list store package
// Word layouts, field widths and opcodes shared by the list store modules.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 5;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [HANDLE_W-1:0] item_handle;
    } t_in_word;

    typedef struct packed {
        logic [HANDLE_W-1:0] read_handle;
        logic                error;
        logic [COUNT_W-1:0]  count;
    } t_out_word;

    // Decoded action for one request, already qualified by the range checks.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
        logic do_read;
        logic error;
    } t_list_ctrl;

endpackage

/* sv/pls_decode.sv */
// ----------------------------------------------------------------------------
// Positional list store request decoder
// Checks a request against the current count and selects the target cell.
// ----------------------------------------------------------------------------
module pls_decode #(
    parameter int CAPACITY = 16,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic [pls_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [pls_pkg::POS_W-1:0]    i_position,
    input  logic [CW-1:0]                i_count,
    output pls_pkg::t_list_ctrl          o_ctrl,
    output logic [IW-1:0]                o_target
);
    import pls_pkg::*;

    // Compare width covers both the position field and the count.
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    logic          w_full;
    logic          w_ok;

    assign w_pos  = PW'(i_position);
    assign w_cnt  = PW'(i_count);
    assign w_full = (i_count == CW'(CAPACITY));

    always_comb begin
        o_ctrl   = '0;
        o_target = w_pos[IW-1:0];
        w_ok     = 1'b0;
        case (i_opcode)
            OP_APPEND: begin
                w_ok             = !w_full;
                o_target         = w_cnt[IW-1:0];
                o_ctrl.do_insert = w_ok;
            end
            OP_INSERT: begin
                w_ok             = !w_full && (w_pos <= w_cnt);
                o_ctrl.do_insert = w_ok;
            end
            OP_READ: begin
                w_ok           = (w_pos < w_cnt);
                o_ctrl.do_read = w_ok;
            end
            OP_REMOVE: begin
                w_ok             = (w_pos < w_cnt);
                o_ctrl.do_remove = w_ok;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        o_ctrl.error = !w_ok;
    end

endmodule

/* sv/pls_cells.sv */
// ----------------------------------------------------------------------------
// Positional list store cell row
// One register per position; each cell loads, shifts or holds in parallel.
// ----------------------------------------------------------------------------
module pls_cells #(
    parameter int CAPACITY = 16,
    parameter int HW       = 16,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  pls_pkg::t_list_ctrl i_ctrl,
    input  logic [IW-1:0]       i_target,
    input  logic [HW-1:0]       i_handle,
    output logic [CW-1:0]       o_count,
    output logic [HW-1:0]       o_read_data
);
    import pls_pkg::*;

    logic [HW-1:0] r_entries [CAPACITY];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_tgt;
    logic          w_ins;
    logic          w_rem;

    assign w_ins = i_update && i_ctrl.do_insert;
    assign w_rem = i_update && i_ctrl.do_remove;
    assign w_tgt = CW'(i_target);

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + 1'b1;
        end else if (w_rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CW-1:0] K      = CW'(g);
        localparam logic [CW:0]   K_NEXT = (CW + 1)'(g + 1);
        logic [HW-1:0] w_prev;
        logic [HW-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_handle;
        end else begin : g_mid_lo
            assign w_prev = r_entries[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = r_entries[g];
        end else begin : g_mid_hi
            assign w_next = r_entries[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ins) begin
                if (K == w_tgt) begin
                    r_entries[g] <= i_handle;
                end else if (K > w_tgt && K <= r_count) begin
                    r_entries[g] <= w_prev;
                end
            end else if (w_rem && K >= w_tgt && K_NEXT < {1'b0, r_count}) begin
                r_entries[g] <= w_next;
            end
        end
    end

    assign o_count     = r_count;
    assign o_read_data = r_entries[i_target];

endmodule

/* sv/positional_list_store_top.sv */
// ----------------------------------------------------------------------------
// Positional list store
// Ordered list of handles with append, insert, read and remove by position.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, and its result word
// is then registered in the result register, from which it is offered.
// Throughput: one word per cycle while the output is not stalled; every cell updates in parallel.
// Reset: i_rst_n is synchronous and active low; it empties the list and
// drops both pipeline valids. Cell contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pls_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pls_pkg::t_out_word o_out_word
);
    import pls_pkg::*;

    // Internal widths: the count must hold CAPACITY itself, a cell index
    // only CAPACITY-1. Stored handles keep at most the field width.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int PW = (CW > COUNT_W) ? CW : COUNT_W;

    // Input register holds the accepted word until the list stage takes it.
    logic      r_in_valid;
    t_in_word  r_in_word;
    // Result register parts the list stage from the downstream stall.
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    logic          w_out_free;
    logic          w_fire;
    t_list_ctrl    w_ctrl;
    logic [IW-1:0] w_target;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_count_next;
    logic [PW-1:0] w_count_ext;
    logic [HW-1:0] w_read_data;

    // The result register can take a new word when it is empty or when its
    // word leaves in this cycle. The input register advances whenever its
    // word is processed, so the input only stalls behind a stalled result.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // Range and capacity checks against the count before this request.
    pls_decode #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .IW       (IW)
    ) u_decode (
        .i_opcode   (r_in_word.opcode),
        .i_position (r_in_word.position),
        .i_count    (w_count),
        .o_ctrl     (w_ctrl),
        .o_target   (w_target)
    );

    // Cell row: shifts up on insert, down on remove, and is only touched
    // when the request passed its checks and the word is processed.
    pls_cells #(
        .CAPACITY (CAPACITY),
        .HW       (HW),
        .CW       (CW),
        .IW       (IW)
    ) u_cells (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_fire),
        .i_ctrl      (w_ctrl),
        .i_target    (w_target),
        .i_handle    (r_in_word.item_handle[HW-1:0]),
        .o_count     (w_count),
        .o_read_data (w_read_data)
    );

    // The reported count is the count after this request.
    always_comb begin
        w_count_next = w_count;
        if (w_ctrl.do_insert) begin
            w_count_next = w_count + 1'b1;
        end else if (w_ctrl.do_remove) begin
            w_count_next = w_count - 1'b1;
        end
    end

    assign w_count_ext = PW'(w_count_next);

    always_comb begin
        n_out_word.read_handle = '0;
        if (w_ctrl.do_read) begin
            n_out_word.read_handle = HANDLE_W'(w_read_data);
        end
        n_out_word.error = w_ctrl.error;
        n_out_word.count = w_count_ext[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
